### rtl/dda_pkg.sv
`timescale 1ns / 1ps

package dda_pkg;

	localparam int YEAR_WIDTH_DEF = 12;
	localparam int MAX_YEAR_RESET = 2026;
	localparam int DAY_W = 5;
	localparam int MONTH_W = 4;
	localparam int MLEN_W = 5;
	localparam int MOFF_W = 9;
	localparam int ELAPSED_MONTHS_W = 4;
	localparam int ELAPSED_DAYS_W = 6;
	localparam int TOTAL_W = 21;
	// day number needs about log2(367) bits above the year width
	localparam int DN_EXTRA = 9;
	localparam int DAYS_PER_YEAR = 365;
	localparam int MONTHS_PER_YEAR = 12;
	// 100 = 4 * 25 and 400 = 16 * 25
	localparam int DIV_BASE = 25;
	localparam int REM_W = 5;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	typedef struct packed {
		logic [DAY_W-1:0]   sd;
		logic [DAY_W-1:0]   ed;
		logic [MONTH_W-1:0] sm;
		logic [MONTH_W-1:0] em;
		logic               order_ok;
	} raw_t;

	function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic lp);
		logic [MLEN_W-1:0] len;
		case (m)
			MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
			MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
			MONTH_FEB: len = lp ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the month in a march-based year, (153*mm+2)/5
	function automatic logic [MOFF_W-1:0] month_off(input logic [MONTH_W-1:0] m);
		logic [MOFF_W-1:0] off;
		case (m)
			MONTH_MAR: off = 9'd0;
			MONTH_APR: off = 9'd31;
			MONTH_MAY: off = 9'd61;
			MONTH_JUN: off = 9'd92;
			MONTH_JUL: off = 9'd122;
			MONTH_AUG: off = 9'd153;
			MONTH_SEP: off = 9'd184;
			MONTH_OCT: off = 9'd214;
			MONTH_NOV: off = 9'd245;
			MONTH_DEC: off = 9'd275;
			MONTH_JAN: off = 9'd306;
			MONTH_FEB: off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

### rtl/dda_div25.sv
`timescale 1ns / 1ps

module dda_div25 #(
	parameter int XW = 10
) (
	input  logic          clk,
	input  logic          en_a,
	input  logic          en_b,
	input  logic [XW-1:0] x,
	output logic [XW-1:0] q,
	output logic [dda_pkg::REM_W-1:0] r
);
	import dda_pkg::*;

	localparam int MUL = (2 ** XW) / DIV_BASE;
	localparam int MW = $clog2(MUL + 2);
	localparam int WW = (XW > 6) ? XW : 6;
	localparam int PW = WW + MW;

	logic [WW-1:0] x_s2;
	logic [PW-1:0] prod_s2;
	logic [WW-1:0] q_est;
	logic [WW-1:0] r_est;
	logic          fix;
	logic [XW-1:0] q_s3;
	logic [REM_W-1:0] r_s3;

	// reciprocal estimate is exact or one low
	always_ff @(posedge clk) begin
		if (en_a) begin
			x_s2    <= WW'(x);
			prod_s2 <= PW'(x) * PW'(MUL);
		end
	end

	always_comb begin
		q_est = WW'(prod_s2 >> XW);
		r_est = x_s2 - q_est * WW'(DIV_BASE);
		fix   = (r_est >= WW'(DIV_BASE));
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			q_s3 <= XW'(fix ? q_est + WW'(1) : q_est);
			r_s3 <= REM_W'(fix ? r_est - WW'(DIV_BASE) : r_est);
		end
	end

	assign q = q_s3;
	assign r = r_s3;

endmodule

### rtl/dda_date_unit.sv
`timescale 1ns / 1ps

module dda_date_unit #(
	parameter int YEAR_WIDTH = dda_pkg::YEAR_WIDTH_DEF
) (
	input  logic                            clk,
	input  dda_pkg::stage_en_t              en,
	input  logic [YEAR_WIDTH-1:0]           max_year,
	input  logic [dda_pkg::DAY_W-1:0]       day,
	input  logic [dda_pkg::MONTH_W-1:0]     month,
	input  logic [YEAR_WIDTH-1:0]           year,
	output logic [YEAR_WIDTH+dda_pkg::DN_EXTRA-1:0] day_num,
	output logic                            date_ok,
	output logic                            leap
);
	import dda_pkg::*;

	localparam int YW = YEAR_WIDTH;
	localparam int DN_W = YW + DN_EXTRA;

	logic               early;
	logic [YW-1:0]      yy;
	logic               rng_ok;

	logic [DAY_W-1:0]   d_s1, d_s2, d_s3;
	logic [MONTH_W-1:0] m_s1, m_s2, m_s3;
	logic [MOFF_W-1:0]  mo_s1;
	logic [DN_W-1:0]    base_s2, base_s3;
	logic [YW-1:0]      yy_s1, yy_s2, yy_s3;
	logic               early_s1, early_s2, early_s3;
	logic               rng_s1, rng_s2, rng_s3;

	logic [YW-3:0]      q100;
	logic [YW-5:0]      q400;
	logic [REM_W-1:0]   r4, r16;

	logic [REM_W-1:0]   res;
	logic               y4, y16, y100, y400, leap_c;
	logic [DN_W-1:0]    dn_c;

	logic [DN_W-1:0]    dn_s4;
	logic               ok_s4, leap_s4;

	// jan and feb count in the previous year
	always_comb begin
		early  = (month <= MONTH_FEB);
		yy     = year - YW'(early);
		rng_ok = (year != '0) && (year <= max_year) && (month >= MONTH_JAN) &&
			(month <= MONTH_DEC) && (day != '0);
	end

	// year, month and day part of the day number; century terms follow the dividers
	always_ff @(posedge clk) begin
		if (en.s1) begin
			d_s1     <= day;
			m_s1     <= month;
			mo_s1    <= month_off(month);
			yy_s1    <= yy;
			early_s1 <= early;
			rng_s1   <= rng_ok;
		end
		if (en.s2) begin
			d_s2     <= d_s1;
			m_s2     <= m_s1;
			base_s2  <= DN_W'(yy_s1) * DN_W'(DAYS_PER_YEAR) + DN_W'(yy_s1[YW-1:2])
				+ DN_W'(mo_s1) + DN_W'(d_s1);
			yy_s2    <= yy_s1;
			early_s2 <= early_s1;
			rng_s2   <= rng_s1;
		end
		if (en.s3) begin
			d_s3     <= d_s2;
			m_s3     <= m_s2;
			base_s3  <= base_s2;
			yy_s3    <= yy_s2;
			early_s3 <= early_s2;
			rng_s3   <= rng_s2;
		end
	end

	dda_div25 #(.XW(YW - 2)) u_div100 (
		.clk  (clk),
		.en_a (en.s2),
		.en_b (en.s3),
		.x    (yy_s1[YW-1:2]),
		.q    (q100),
		.r    (r4)
	);

	dda_div25 #(.XW(YW - 4)) u_div400 (
		.clk  (clk),
		.en_a (en.s2),
		.en_b (en.s3),
		.x    (yy_s1[YW-1:4]),
		.q    (q400),
		.r    (r16)
	);

	// leap test of the real year from yy; for jan/feb yy is year-1,
	// so divisibility shows as all-ones low bits and a residue of DIV_BASE-1
	always_comb begin
		res    = early_s3 ? REM_W'(DIV_BASE - 1) : '0;
		y4     = early_s3 ? (yy_s3[1:0] == 2'b11) : (yy_s3[1:0] == 2'b00);
		y16    = early_s3 ? (yy_s3[3:0] == 4'hf) : (yy_s3[3:0] == 4'h0);
		y100   = y4 && (r4 == res);
		y400   = y16 && (r16 == res);
		leap_c = y4 && (!y100 || y400);
		dn_c   = base_s3 - DN_W'(q100) + DN_W'(q400);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			dn_s4   <= dn_c;
			ok_s4   <= rng_s3 && (MLEN_W'(d_s3) <= month_len(m_s3, leap_c));
			leap_s4 <= leap_c;
		end
	end

	assign day_num = dn_s4;
	assign date_ok = ok_s4;
	assign leap    = leap_s4;

endmodule

### rtl/date_difference_age_core.sv
`timescale 1ns / 1ps
// five register stages: a date pair taken into the first passes the three
// middle stages and shows its result when the output stage takes it
// throughput one date pair per cycle while out_ready is high; each stage holds
// only while the one after it is full and stalled, so bubbles close up
// reset clears v_s1 to v_s5 and loads max_year with 2026 cut to the year width
module date_difference_age_core #(
	parameter int YEAR_WIDTH = dda_pkg::YEAR_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [YEAR_WIDTH-1:0]                cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dda_pkg::DAY_W-1:0]            start_day,
	input  logic [dda_pkg::MONTH_W-1:0]          start_month,
	input  logic [YEAR_WIDTH-1:0]                start_year,
	input  logic [dda_pkg::DAY_W-1:0]            end_day,
	input  logic [dda_pkg::MONTH_W-1:0]          end_month,
	input  logic [YEAR_WIDTH-1:0]                end_year,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 dates_valid,
	output logic [YEAR_WIDTH-1:0]                elapsed_years,
	output logic [dda_pkg::ELAPSED_MONTHS_W-1:0] elapsed_months,
	output logic signed [dda_pkg::ELAPSED_DAYS_W-1:0] elapsed_days,
	output logic [dda_pkg::TOTAL_W-1:0]          total_days
);
	import dda_pkg::*;

	localparam int YW = YEAR_WIDTH;
	localparam int DN_W = YW + DN_EXTRA;
	localparam int DIFF_W = (DN_W > TOTAL_W) ? DN_W : TOTAL_W;

	logic [YW-1:0] max_year_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	stage_en_t en;

	raw_t          raw_c, raw_s1, raw_s2, raw_s3, raw_s4;
	logic [YW-1:0] dy_s1, dy_s2, dy_s3, dy_s4;

	logic [DN_W-1:0] dn_s, dn_e;
	logic            ok_s, ok_e;
	logic            leap_s, leap_e;

	logic                    ok_c;
	logic                    neg;
	logic [MLEN_W-1:0]       prev_len;
	logic [6:0]              days_c;
	logic [4:0]              mon_c;
	logic                    borrow;
	logic [DIFF_W-1:0]       diff_c;

	logic                        valid_s5;
	logic [YW-1:0]               years_s5;
	logic [ELAPSED_MONTHS_W-1:0] months_s5;
	logic [ELAPSED_DAYS_W-1:0]   days_s5;
	logic [TOTAL_W-1:0]          total_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_year_q <= YW'(MAX_YEAR_RESET);
		end else if (cfg_we) begin
			max_year_q <= cfg_wdata;
		end
	end

	// a stage takes a new beat when it is empty or its content moves on
	always_comb begin
		rdy5     = !v_s5 || out_ready;
		rdy4     = !v_s4 || rdy5;
		rdy3     = !v_s3 || rdy4;
		rdy2     = !v_s2 || rdy3;
		rdy1     = !v_s1 || rdy2;
		in_ready = rdy1;
		en.s1    = rdy1;
		en.s2    = rdy2;
		en.s3    = rdy3;
		en.s4    = rdy4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		raw_c.sd = start_day;
		raw_c.ed = end_day;
		raw_c.sm = start_month;
		raw_c.em = end_month;
		raw_c.order_ok = (end_year > start_year) || ((end_year == start_year) &&
			((end_month > start_month) ||
			((end_month == start_month) && (end_day >= start_day))));
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			raw_s1 <= raw_c;
			dy_s1  <= end_year - start_year;
		end
		if (en.s2) begin
			raw_s2 <= raw_s1;
			dy_s2  <= dy_s1;
		end
		if (en.s3) begin
			raw_s3 <= raw_s2;
			dy_s3  <= dy_s2;
		end
		if (en.s4) begin
			raw_s4 <= raw_s3;
			dy_s4  <= dy_s3;
		end
	end

	dda_date_unit #(.YEAR_WIDTH(YW)) u_start (
		.clk      (clk),
		.en       (en),
		.max_year (max_year_q),
		.day      (start_day),
		.month    (start_month),
		.year     (start_year),
		.day_num  (dn_s),
		.date_ok  (ok_s),
		.leap     (leap_s)
	);

	dda_date_unit #(.YEAR_WIDTH(YW)) u_end (
		.clk      (clk),
		.en       (en),
		.max_year (max_year_q),
		.day      (end_day),
		.month    (end_month),
		.year     (end_year),
		.day_num  (dn_e),
		.date_ok  (ok_e),
		.leap     (leap_e)
	);

	// day borrow uses the month before the end month; january borrows december
	always_comb begin
		ok_c     = ok_s && ok_e && raw_s4.order_ok;
		neg      = (raw_s4.ed < raw_s4.sd);
		prev_len = (raw_s4.em == MONTH_JAN) ? month_len(MONTH_DEC, 1'b0) :
			month_len(raw_s4.em - 4'd1, leap_e);
		days_c   = neg ? 7'(raw_s4.ed) + 7'(prev_len) - 7'(raw_s4.sd) :
			7'(raw_s4.ed) - 7'(raw_s4.sd);
		mon_c    = 5'(raw_s4.em) - 5'(raw_s4.sm) - 5'(neg);
		borrow   = mon_c[4];
		if (borrow) begin
			mon_c = mon_c + 5'(MONTHS_PER_YEAR);
		end
		diff_c   = DIFF_W'(dn_e) - DIFF_W'(dn_s);
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			valid_s5  <= ok_c;
			years_s5  <= ok_c ? dy_s4 - YW'(borrow) : '0;
			months_s5 <= ok_c ? mon_c[ELAPSED_MONTHS_W-1:0] : '0;
			days_s5   <= ok_c ? days_c[ELAPSED_DAYS_W-1:0] : '0;
			total_s5  <= ok_c ? diff_c[TOTAL_W-1:0] : '0;
		end
	end

	assign out_valid      = v_s5;
	assign dates_valid    = valid_s5;
	assign elapsed_years  = years_s5;
	assign elapsed_months = months_s5;
	assign elapsed_days   = days_s5;
	assign total_days     = total_s5;

	// input only backs up when every stage is full and the output is stalled
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready))
		else $error("input stalled with a free stage");

	a_months_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dates_valid) |-> (elapsed_months <= 4'd11))
		else $error("elapsed months out of range");

	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dates_valid) |-> (elapsed_days >= -6'sd3))
		else $error("elapsed days below minimum");

	a_same_day: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dates_valid && (total_days == '0)) |->
		((elapsed_years == '0) && (elapsed_months == '0) && (elapsed_days == '0)))
		else $error("zero day count with nonzero elapsed fields");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !dates_valid) |-> ((total_days == '0) && (elapsed_years == '0)))
		else $error("invalid beat carries data");

endmodule

### dv/tb_date_difference_age_core.sv
`timescale 1ns / 1ps

module tb_date_difference_age_core;

	import dda_pkg::*;

	localparam int YW = YEAR_WIDTH_DEF;
	localparam int N_DIR = 24;

	typedef struct packed {
		logic [DAY_W-1:0]   sd;
		logic [MONTH_W-1:0] sm;
		logic [YW-1:0]      sy;
		logic [DAY_W-1:0]   ed;
		logic [MONTH_W-1:0] em;
		logic [YW-1:0]      ey;
	} date_pair_t;

	typedef struct packed {
		logic                             ok;
		logic [YW-1:0]                    yrs;
		logic [ELAPSED_MONTHS_W-1:0]      mons;
		logic signed [ELAPSED_DAYS_W-1:0] dys;
		logic [TOTAL_W-1:0]               total;
	} age_t;

	typedef struct packed {
		date_pair_t pair;
		logic       typed;
		age_t       want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [YW-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [DAY_W-1:0] start_day;
	logic [MONTH_W-1:0] start_month;
	logic [YW-1:0] start_year;
	logic [DAY_W-1:0] end_day;
	logic [MONTH_W-1:0] end_month;
	logic [YW-1:0] end_year;
	logic out_valid;
	logic out_ready;
	logic dates_valid;
	logic [YW-1:0] elapsed_years;
	logic [ELAPSED_MONTHS_W-1:0] elapsed_months;
	logic signed [ELAPSED_DAYS_W-1:0] elapsed_days;
	logic [TOTAL_W-1:0] total_days;

	age_t ages_due[$];
	int year_limit = MAX_YEAR_RESET;
	int fail_count = 0;
	bit tx_burst = 0;
	bit rx_burst = 0;

	// invalid rows and obvious answers carry their result, the rest go to the predictor
	dir_row_t dir_tab [N_DIR] = '{
		'{'{1, MONTH_JAN, 1, 1, MONTH_JAN, 1}, 1'b1, '{1'b1, 0, 0, 0, 0}},
		'{'{31, MONTH_DEC, 2026, 31, MONTH_DEC, 2026}, 1'b1, '{1'b1, 0, 0, 0, 0}},
		'{'{1, MONTH_JAN, 1, 1, MONTH_JAN, 2}, 1'b1, '{1'b1, 1, 0, 0, 365}},
		'{'{1, MONTH_JAN, 1, 31, MONTH_DEC, 2026}, 1'b0, '0},
		'{'{31, MONTH_JAN, 2023, 1, MONTH_MAR, 2023}, 1'b1, '{1'b1, 0, 1, -2, 29}},
		'{'{31, MONTH_JAN, 2024, 1, MONTH_MAR, 2024}, 1'b0, '0},
		'{'{30, MONTH_JAN, 2023, 1, MONTH_MAR, 2023}, 1'b0, '0},
		'{'{20, MONTH_DEC, 2020, 5, MONTH_JAN, 2021}, 1'b0, '0},
		'{'{29, MONTH_FEB, 2024, 28, MONTH_FEB, 2025}, 1'b0, '0},
		'{'{29, MONTH_FEB, 2000, 1, MONTH_MAR, 2000}, 1'b0, '0},
		'{'{15, MONTH_JUN, 2000, 10, MONTH_JUN, 2026}, 1'b0, '0},
		'{'{29, MONTH_FEB, 2023, 1, MONTH_MAR, 2023}, 1'b1, '0},
		'{'{29, MONTH_FEB, 1900, 1, MONTH_JAN, 2000}, 1'b1, '0},
		'{'{1, 0, 2000, 1, MONTH_JAN, 2001}, 1'b1, '0},
		'{'{1, MONTH_JAN, 2000, 1, 13, 2001}, 1'b1, '0},
		'{'{1, 15, 2000, 1, MONTH_JAN, 2001}, 1'b1, '0},
		'{'{0, MONTH_MAY, 2000, 1, MONTH_JAN, 2001}, 1'b1, '0},
		'{'{1, MONTH_MAY, 2000, 31, MONTH_APR, 2001}, 1'b1, '0},
		'{'{1, MONTH_MAY, 0, 1, MONTH_JAN, 2001}, 1'b1, '0},
		'{'{1, MONTH_MAY, 2000, 1, MONTH_JAN, 2027}, 1'b1, '0},
		'{'{31, 15, 4095, 31, 15, 4095}, 1'b1, '0},
		'{'{1, MONTH_MAY, 2010, 1, MONTH_JUN, 2009}, 1'b1, '0},
		'{'{1, MONTH_MAY, 2010, 1, MONTH_APR, 2010}, 1'b1, '0},
		'{'{12, MONTH_MAY, 2010, 11, MONTH_MAY, 2010}, 1'b1, '0}
	};

	date_difference_age_core #(
		.YEAR_WIDTH(YW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_day(start_day),
		.start_month(start_month),
		.start_year(start_year),
		.end_day(end_day),
		.end_month(end_month),
		.end_year(end_year),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dates_valid(dates_valid),
		.elapsed_years(elapsed_years),
		.elapsed_months(elapsed_months),
		.elapsed_days(elapsed_days),
		.total_days(total_days)
	);

	function automatic bit is_leap(input int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int days_in_month(input int m, input int y);
		case (m)
			MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
			MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
			MONTH_FEB: return is_leap(y) ? 29 : 28;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_good(input int d, input int m, input int y, input int lim);
		return (y >= 1) && (y <= lim) && (m >= 1) && (m <= 12) &&
			(d >= 1) && (d <= days_in_month(m, y));
	endfunction

	// march-based serial day number, year must be at least 1
	function automatic int serial_day(input int d, input int m, input int y);
		int yy;
		int mm;
		yy = (m <= 2) ? y - 1 : y;
		mm = (m + 9) % 12;
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + d;
	endfunction

	function automatic age_t compute_age(input date_pair_t p, input int lim);
		age_t r;
		int yrs;
		int mons;
		int dys;
		int pm;
		int py;
		r = '0;
		if (!date_good(int'(p.sd), int'(p.sm), int'(p.sy), lim) ||
			!date_good(int'(p.ed), int'(p.em), int'(p.ey), lim))
			return r;
		if ({p.sy, p.sm, p.sd} > {p.ey, p.em, p.ed})
			return r;
		yrs = int'(p.ey) - int'(p.sy);
		mons = int'(p.em) - int'(p.sm);
		dys = int'(p.ed) - int'(p.sd);
		if (dys < 0) begin
			mons--;
			pm = int'(p.em) - 1;
			py = int'(p.ey);
			// borrow from december of the year before
			if (pm == 0) begin
				pm = 12;
				py = int'(p.ey) - 1;
			end
			dys = int'(p.ed) + days_in_month(pm, py) - int'(p.sd);
		end
		if (mons < 0) begin
			yrs--;
			mons += 12;
		end
		r.ok = 1'b1;
		r.yrs = YW'(yrs);
		r.mons = ELAPSED_MONTHS_W'(mons);
		r.dys = ELAPSED_DAYS_W'(dys);
		r.total = TOTAL_W'(serial_day(int'(p.ed), int'(p.em), int'(p.ey)) -
			serial_day(int'(p.sd), int'(p.sm), int'(p.sy)));
		return r;
	endfunction

	function automatic int rand_year(input int top);
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return (top > 4) ? $urandom_range(top - 3, top) : $urandom_range(1, top);
		if (pick == 1)
			return $urandom_range(1, (top < 4) ? top : 4);
		return $urandom_range(1, top);
	endfunction

	function automatic date_pair_t gen_pair(input int lim);
		date_pair_t p;
		date_pair_t sw;
		int top;
		int kind;
		int len;
		int ey;
		top = (lim < 1) ? 4095 : lim;
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			p = $bits(date_pair_t)'({$urandom, $urandom});
			return p;
		end
		p.sy = YW'(rand_year(top));
		case ($urandom_range(0, 2))
			0: p.ey = p.sy;
			1: begin
				ey = int'(p.sy) + $urandom_range(0, 2);
				p.ey = YW'((ey > top) ? top : ey);
			end
			default: p.ey = YW'(rand_year(top));
		endcase
		p.sm = 4'($urandom_range(1, 12));
		p.em = ($urandom_range(0, 3) == 0) ? p.sm : 4'($urandom_range(1, 12));
		p.sd = 5'($urandom_range(1, days_in_month(int'(p.sm), int'(p.sy))));
		p.ed = 5'($urandom_range(1, days_in_month(int'(p.em), int'(p.ey))));
		// leap days on either side
		if ($urandom_range(0, 7) == 0 && is_leap(int'(p.sy))) begin
			p.sm = MONTH_FEB;
			p.sd = 5'd29;
		end
		if ($urandom_range(0, 7) == 0 && is_leap(int'(p.ey))) begin
			p.em = MONTH_FEB;
			p.ed = 5'd29;
		end
		if (kind < 5) begin
			// break one field of an otherwise sane pair
			case ($urandom_range(0, 5))
				0: begin
					len = days_in_month(int'(p.sm), int'(p.sy));
					p.sd = (len >= 31) ? 5'd0 : 5'($urandom_range(len + 1, 31));
				end
				1: p.em = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
				2: p.sy = '0;
				3: p.ey = YW'(top + 1);
				4: p.ed = '0;
				default: p.sm = 4'($urandom_range(13, 15));
			endcase
		end else if (kind < 17 && {p.sy, p.sm, p.sd} > {p.ey, p.em, p.ed}) begin
			sw = p;
			p.sd = sw.ed;
			p.sm = sw.em;
			p.sy = sw.ey;
			p.ed = sw.sd;
			p.em = sw.sm;
			p.ey = sw.sy;
		end
		return p;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic send_pair(input date_pair_t p, input logic typed, input age_t want);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_day <= p.sd;
		start_month <= p.sm;
		start_year <= p.sy;
		end_day <= p.ed;
		end_month <= p.em;
		end_year <= p.ey;
		do @(posedge clk); while (!in_ready);
		ages_due.push_back(typed ? want : compute_age(p, year_limit));
	endtask

	task automatic write_year_limit(input logic [YW-1:0] v);
		in_valid <= 1'b0;
		while (ages_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		year_limit = int'(v);
	endtask

	task automatic check_beat();
		age_t want;
		if (ages_due.size() == 0) begin
			note_mismatch("result beat with nothing pending");
			return;
		end
		want = ages_due.pop_front();
		if (dates_valid !== want.ok)
			note_mismatch($sformatf("dates_valid got %0b want %0b", dates_valid, want.ok));
		if (elapsed_years !== want.yrs)
			note_mismatch($sformatf("elapsed_years got %0d want %0d", elapsed_years,
				want.yrs));
		if (elapsed_months !== want.mons)
			note_mismatch($sformatf("elapsed_months got %0d want %0d", elapsed_months,
				want.mons));
		if (elapsed_days !== want.dys)
			note_mismatch($sformatf("elapsed_days got %0d want %0d", elapsed_days,
				want.dys));
		if (total_days !== want.total)
			note_mismatch($sformatf("total_days got %0d want %0d", total_days, want.total));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls, sometimes a long run with ready held high
	initial begin
		int stall;
		int beats;
		beats = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (beats % 64 == 0)
				rx_burst = ($urandom_range(0, 3) == 0);
			stall = rx_burst ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_beat();
			beats++;
		end
	end

	initial begin
		int n;
		int ph;
		int count;
		logic [YW-1:0] lim;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		start_day <= '0;
		start_month <= '0;
		start_year <= '0;
		end_day <= '0;
		end_month <= '0;
		end_year <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIR; n++)
			send_pair(dir_tab[n].pair, dir_tab[n].typed, dir_tab[n].want);

		// year limit sweep: top, bottom, zero, arbitrary, back to the reset value
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin lim = '1; count = 400; end
				1: begin lim = YW'(1); count = 150; end
				2: begin lim = '0; count = 100; end
				3: begin lim = YW'($urandom_range(2, 4094)); count = 350; end
				default: begin lim = YW'(MAX_YEAR_RESET); count = 300; end
			endcase
			write_year_limit(lim);
			for (n = 0; n < count; n++) begin
				if (n % 64 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				send_pair(gen_pair(year_limit), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (ages_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
